// ===== rtl/lcg_rir_pkg.sv =====
`default_nettype none

package lcg_rir_pkg;

    // Seed and result word width
    localparam int unsigned SEED_W = 32;
    // Divider step counter width, one step per dividend bit
    localparam int unsigned CNT_W = $clog2(SEED_W);

    // Generator constants
    localparam logic [SEED_W-1:0] LCG_MUL = 32'h0003_43FD;
    localparam logic [SEED_W-1:0] LCG_ADD = 32'h0026_9EC3;

    // Default exclusive bound on max - min
    localparam int unsigned RANGE_LIMIT_DEF = 32767;

    // Controller to datapath commands
    typedef struct packed {
        logic load_seed;
        logic capture;
        logic check;
        logic advance;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic range_err;
        logic div_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/lcg_random_in_range.sv =====
// Flow: an accepted draw beat passes through the range check, the seed
// advance, 32 restoring divider steps and the output load; a range error
// skips the advance and the divider. A reseed beat only loads the seed.
// The remainder unit is bit-serial; no beat is taken until the result loads.
// Reset (aresetn low, synchronous): seed cleared to 0, controller idle,
// no result pending.
`default_nettype none

module lcg_random_in_range #(
    parameter int unsigned RANGE_LIMIT = lcg_rir_pkg::RANGE_LIMIT_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_func,
    input  wire logic signed [lcg_rir_pkg::SEED_W-1:0] s_min_value,
    input  wire logic signed [lcg_rir_pkg::SEED_W-1:0] s_max_value,
    input  wire logic [lcg_rir_pkg::SEED_W-1:0]        s_new_seed,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [lcg_rir_pkg::SEED_W-1:0]      m_value,
    output logic                                       m_range_error,
    output logic                                       m_bounds_swapped
);

    lcg_rir_pkg::dp_cmd_t    cmd;
    lcg_rir_pkg::dp_status_t status;

    lcg_rir_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    lcg_rir_dp #(
        .RANGE_LIMIT (RANGE_LIMIT)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .in_min             (s_min_value),
        .in_max             (s_max_value),
        .in_seed            (s_new_seed),
        .out_value          (m_value),
        .out_range_error    (m_range_error),
        .out_bounds_swapped (m_bounds_swapped)
    );

endmodule

`default_nettype wire

// ===== rtl/lcg_rir_dp.sv =====
`default_nettype none

module lcg_rir_dp #(
    parameter int unsigned RANGE_LIMIT = lcg_rir_pkg::RANGE_LIMIT_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire lcg_rir_pkg::dp_cmd_t                cmd,
    output lcg_rir_pkg::dp_status_t                  status,
    input  wire logic signed [lcg_rir_pkg::SEED_W-1:0] in_min,
    input  wire logic signed [lcg_rir_pkg::SEED_W-1:0] in_max,
    input  wire logic [lcg_rir_pkg::SEED_W-1:0]      in_seed,
    output logic signed [lcg_rir_pkg::SEED_W-1:0]    out_value,
    output logic                                     out_range_error,
    output logic                                     out_bounds_swapped
);

    localparam int unsigned W = lcg_rir_pkg::SEED_W;
    // Divisor is at most RANGE_LIMIT
    localparam int unsigned DIV_W = $clog2(RANGE_LIMIT + 1);

    logic [W-1:0]                     seed_reg;
    logic signed [W-1:0]              lo_reg;
    logic signed [W-1:0]              hi_reg;
    logic                             swap_reg;
    logic                             err_reg;
    logic [DIV_W-1:0]                 d_reg;
    logic [W-1:0]                     quo_reg;
    logic [DIV_W-1:0]                 rem_reg;
    logic [DIV_W-1:0]                 dsr_reg;
    logic [lcg_rir_pkg::CNT_W-1:0]    cnt_reg;
    logic signed [W-1:0]              value_reg;
    logic                             oerr_reg;
    logic                             oswap_reg;

    logic                             swap_in;
    logic [W:0]                       diff;
    logic                             too_wide;
    logic [W-1:0]                     seed_adv;
    logic [DIV_W:0]                   rem_sh;
    logic [DIV_W-1:0]                 rem_next;

    // Bound ordering on the incoming beat
    assign swap_in = (in_max < in_min);

    // Exact range, never negative after the swap
    assign diff     = {hi_reg[W-1], hi_reg} - {lo_reg[W-1], lo_reg};
    assign too_wide = (diff >= (W+1)'(RANGE_LIMIT));

    // Next generator state
    assign seed_adv = W'(seed_reg * lcg_rir_pkg::LCG_MUL) + lcg_rir_pkg::LCG_ADD;

    // One restoring division step
    always_comb begin
        rem_sh = {rem_reg, quo_reg[W-1]};
        if (rem_sh >= {1'b0, dsr_reg}) begin
            rem_next = DIV_W'(rem_sh - {1'b0, dsr_reg});
        end else begin
            rem_next = rem_sh[DIV_W-1:0];
        end
    end

    assign status.range_err = too_wide;
    assign status.div_last  = (cnt_reg == lcg_rir_pkg::CNT_W'(W - 1));

    // Seed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (cmd.load_seed) begin
            seed_reg <= in_seed;
        end else if (cmd.advance) begin
            seed_reg <= seed_adv;
        end
    end

    // Operand capture, range check and divider
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            lo_reg   <= swap_in ? in_max : in_min;
            hi_reg   <= swap_in ? in_min : in_max;
            swap_reg <= swap_in;
        end
        if (cmd.check) begin
            err_reg <= too_wide;
            d_reg   <= diff[DIV_W-1:0];
        end
        if (cmd.advance) begin
            quo_reg <= seed_adv;
            rem_reg <= '0;
            dsr_reg <= d_reg + DIV_W'(1);
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[W-2:0], 1'b0};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + lcg_rir_pkg::CNT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            value_reg <= err_reg ? '0 : lo_reg + W'(rem_reg);
            oerr_reg  <= err_reg;
            oswap_reg <= swap_reg;
        end
    end

    assign out_value          = value_reg;
    assign out_range_error    = oerr_reg;
    assign out_bounds_swapped = oswap_reg;

endmodule

`default_nettype wire

// ===== rtl/lcg_rir_ctrl.sv =====
`default_nettype none

module lcg_rir_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_func,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output lcg_rir_pkg::dp_cmd_t          cmd,
    input  wire lcg_rir_pkg::dp_status_t  status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ADV,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    // Next state and datapath commands
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_func) begin
                        cmd.load_seed = 1'b1;
                    end else begin
                        cmd.capture = 1'b1;
                        state_next  = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = status.range_err ? ST_DONE : ST_ADV;
            end
            ST_ADV: begin
                cmd.advance = 1'b1;
                state_next  = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lcg_rir_checker.sv =====
`default_nettype none

module lcg_rir_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_func,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_value,
    input wire logic        m_range_error
);

    // No result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Error beats carry a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> m_value == 32'd0)
        else $error("range error with nonzero value");

    // A draw beat occupies the block
    a_draw_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_func |=> !s_ready)
        else $error("input ready right after a draw beat");

    // A reseed beat completes at once
    a_reseed_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func |=> s_ready)
        else $error("input stalled after a reseed beat");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value))
        else $error("result beat dropped or changed while stalled");

endmodule

bind lcg_random_in_range lcg_rir_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_func        (s_func),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_value       (m_value),
    .m_range_error (m_range_error)
);

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned       SEED_W          = lcg_rir_pkg::SEED_W;
    localparam int unsigned       RANGE_LIMIT_DEF = lcg_rir_pkg::RANGE_LIMIT_DEF;
    localparam logic [SEED_W-1:0] LCG_MUL         = lcg_rir_pkg::LCG_MUL;
    localparam logic [SEED_W-1:0] LCG_ADD         = lcg_rir_pkg::LCG_ADD;

    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RANDOM_BEATS = 1200;
    localparam int unsigned DRAIN_CYCLES = 60;

    // One expected draw result
    typedef struct {
        logic signed [SEED_W-1:0] value;
        logic                     range_error;
        logic                     bounds_swapped;
    } draw_result_t;

    // Tracks the generator seed and the draw results still owed by the block
    class draw_scoreboard;
        logic [SEED_W-1:0] seed;
        draw_result_t      expected_draws[$];
        int unsigned       mismatches;

        function new();
            seed       = '0;
            mismatches = 0;
        endfunction

        // Accepted input beat: update the seed and queue the draw outcome
        function void predict_draw(logic func, logic signed [SEED_W-1:0] min_v,
                                   logic signed [SEED_W-1:0] max_v,
                                   logic [SEED_W-1:0] new_seed);
            longint            lo;
            longint            hi;
            longint            tmp;
            longint            span;
            logic [SEED_W-1:0] rem;
            draw_result_t      res;

            if (func) begin
                seed = new_seed;
                return;
            end
            lo = longint'(min_v);
            hi = longint'(max_v);
            res.bounds_swapped = 1'b0;
            if (hi < lo) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
                res.bounds_swapped = 1'b1;
            end
            // exact difference, never overflows in 64 bits
            span = hi - lo;
            if (span >= longint'(RANGE_LIMIT_DEF)) begin
                res.value       = '0;
                res.range_error = 1'b1;
            end else begin
                seed = seed * LCG_MUL + LCG_ADD;
                rem  = seed % SEED_W'(span + 1);
                res.value       = SEED_W'(lo) + rem;
                res.range_error = 1'b0;
            end
            expected_draws.push_back(res);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Accepted result beat: compare with the oldest expected draw
        task check_beat(logic signed [SEED_W-1:0] value, logic range_error,
                        logic bounds_swapped);
            draw_result_t exp_r;

            if (expected_draws.size() == 0) begin
                report("result beat with no draw pending");
                return;
            end
            exp_r = expected_draws.pop_front();
            if (value !== exp_r.value)
                report($sformatf("value got %0d exp %0d", value, exp_r.value));
            if (range_error !== exp_r.range_error)
                report($sformatf("range_error got %b exp %b", range_error,
                                 exp_r.range_error));
            if (bounds_swapped !== exp_r.bounds_swapped)
                report($sformatf("bounds_swapped got %b exp %b", bounds_swapped,
                                 exp_r.bounds_swapped));
        endtask

        function int unsigned outstanding();
            return expected_draws.size();
        endfunction
    endclass

    logic                     aclk             = 1'b0;
    logic                     aresetn          = 1'b0;
    logic                     s_valid          = 1'b0;
    logic                     s_ready;
    logic                     s_func           = 1'b0;
    logic signed [SEED_W-1:0] s_min_value      = '0;
    logic signed [SEED_W-1:0] s_max_value      = '0;
    logic [SEED_W-1:0]        s_new_seed       = '0;
    logic                     m_valid;
    logic                     m_ready          = 1'b0;
    logic signed [SEED_W-1:0] m_value;
    logic                     m_range_error;
    logic                     m_bounds_swapped;

    logic                     hold_rx          = 1'b0;
    int unsigned              beats_sent       = 0;

    draw_scoreboard sb = new();

    lcg_random_in_range dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_min_value      (s_min_value),
        .s_max_value      (s_max_value),
        .s_new_seed       (s_new_seed),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_value          (m_value),
        .m_range_error    (m_range_error),
        .m_bounds_swapped (m_bounds_swapped)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Offer one input beat after a random gap and wait for its acceptance
    task automatic send_beat(logic func, logic signed [SEED_W-1:0] min_v,
                             logic signed [SEED_W-1:0] max_v,
                             logic [SEED_W-1:0] new_seed);
        int unsigned gap;

        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= func;
        s_min_value <= min_v;
        s_max_value <= max_v;
        s_new_seed  <= new_seed;
        do @(posedge aclk); while (!s_ready);
        sb.predict_draw(func, min_v, max_v, new_seed);
        beats_sent++;
    endtask

    task automatic send_draw(logic signed [SEED_W-1:0] min_v,
                             logic signed [SEED_W-1:0] max_v);
        send_beat(1'b0, min_v, max_v, $urandom);
    endtask

    task automatic send_reseed(logic [SEED_W-1:0] new_seed);
        send_beat(1'b1, $urandom, $urandom, new_seed);
    endtask

    // Random beat: mostly in-range draws, some out-of-range, some reseeds
    task automatic send_random_beat();
        int unsigned kind;
        longint      lo;
        longint      hi;
        longint      span;

        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            send_reseed($urandom);
            return;
        end
        lo = longint'($signed($urandom));
        if (kind < 16) begin
            hi = longint'($signed($urandom));
        end else begin
            if (kind < 22)
                span = $urandom_range(RANGE_LIMIT_DEF, RANGE_LIMIT_DEF + 64);
            else if (kind < 30)
                span = $urandom_range(RANGE_LIMIT_DEF - 16, RANGE_LIMIT_DEF - 1);
            else if (kind < 60)
                span = $urandom_range(0, 15);
            else
                span = $urandom_range(0, RANGE_LIMIT_DEF - 1);
            hi = lo + span;
            if (hi > 64'sd2147483647)
                hi = lo - span;
        end
        if ($urandom_range(0, 3) == 0)
            send_draw(SEED_W'(hi), SEED_W'(lo));
        else
            send_draw(SEED_W'(lo), SEED_W'(hi));
    endtask

    // Result side: random stall per beat, plus the long hold-off
    initial begin
        int unsigned gap;

        wait (aresetn);
        forever begin
            gap = $urandom_range(0, 9);
            if (gap > 0 || hold_rx) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
                while (hold_rx) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_beat(m_value, m_range_error, m_bounds_swapped);
        end
    end

    // Long receiver hold-off while the sender keeps offering beats
    initial begin
        wait (beats_sent >= 200);
        @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    // Reset, directed beats, random beats, drain
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // equal bounds from the reset seed, then at both extremes
        send_draw(0, 0);
        send_draw(32'sh8000_0000, 32'sh8000_0000);
        send_draw(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        // ordinary and reversed bounds
        send_draw(-5, 5);
        send_draw(5, -5);
        // widest legal range, and the first range that is too large
        send_draw(0, RANGE_LIMIT_DEF - 1);
        send_draw(0, RANGE_LIMIT_DEF);
        send_draw(RANGE_LIMIT_DEF, 0);
        // differences that do not fit in 31 bits, plain and reversed
        send_draw(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_draw(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_draw(-1, 32'sh7FFF_FFFF);
        // legal ranges hugging each end of the signed scale
        send_draw(32'sh7FFF_FFFF - (RANGE_LIMIT_DEF - 1), 32'sh7FFF_FFFF);
        send_draw(32'sh8000_0000 + (RANGE_LIMIT_DEF - 1), 32'sh8000_0000);
        // reseeds with ignored bounds, draws with ignored seed field
        send_reseed(32'hFFFF_FFFF);
        send_draw(-100, -100);
        send_draw(-3, 3);
        send_reseed(32'h0000_0000);
        send_reseed(32'h1234_5678);
        send_draw(1000, -1000);
        send_beat(1'b0, 32'sh0000_0010, 32'sh0000_0020, 32'hFFFF_FFFF);
        send_draw(32'sh8000_0000, 32'sh8000_0000 + RANGE_LIMIT_DEF);

        for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
            // sender pause until the block has handed back everything
            if (i == RANDOM_BEATS / 2 && sb.outstanding() != 0) begin
                s_valid <= 1'b0;
                while (sb.outstanding() != 0) @(posedge aclk);
            end
            send_random_beat();
        end
        s_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
